// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;
  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int LEVELS     = IDX_W + 1;
  localparam int LVL_W      = $clog2(LEVELS + 1);
  localparam int CNT_W      = 11;
  localparam logic [LINK_W-1:0] NIL_LINK = {LINK_W{1'b1}};
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_RB_CLR = 14'b00000000000010,
    ST_RB_ADD = 14'b00000000000100,
    ST_DEC    = 14'b00000000001000,
    ST_A_SCAN = 14'b00000000010000,
    ST_A_RD   = 14'b00000000100000,
    ST_A_HEAD = 14'b00000001000000,
    ST_A_SPL  = 14'b00000010000000,
    ST_F_LVL  = 14'b00000100000000,
    ST_F_RD   = 14'b00001000000000,
    ST_F_CMP  = 14'b00010000000000,
    ST_APP    = 14'b00100000000000,
    ST_DONE   = 14'b01000000000000,
    ST_APP2   = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } link_req_t;

  function automatic logic [LVL_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int k = CNT_W - 1; k >= 0; k--) begin
      if (n > (CNT_W'(1) << k)) begin
        l = LVL_W'(k + 1);
        break;
      end
    end
    return l;
  endfunction

  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (n[k]) l = LVL_W'(k);
    end
    return l;
  endfunction
endpackage

// ===== rtl/core/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: rebuild sweep, allocate with split, free with buddy merge.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              start,
  input  logic              cmd,
  input  logic [CNT_W-1:0]  req,
  input  logic [IDX_W-1:0]  idx,
  input  logic [LINK_W-1:0] link_rdata,
  output link_req_t         link_req,
  output logic              busy,
  output logic              done,
  output logic              ok,
  output logic [IDX_W-1:0]  res_idx,
  output logic [CNT_W-1:0]  free_cnt
);
  state_t state_r, state_nxt;
  logic [LINK_W-1:0] head_r [LEVELS];
  logic [LINK_W-1:0] tail_r [LEVELS];
  logic [LINK_W-1:0] head_nxt [LEVELS];
  logic [LINK_W-1:0] tail_nxt [LEVELS];
  logic [CNT_W-1:0]  total_r, total_nxt, eff_r, eff_nxt;
  logic [LVL_W-1:0]  top_r, top_nxt, lvl_r, lvl_nxt, cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, ptr_r, ptr_nxt;
  logic [LINK_W-1:0] node_r, node_nxt, prev_r, prev_nxt, tgt_r, tgt_nxt;
  logic [LINK_W-1:0] app_r, app_nxt;
  logic [LVL_W-1:0]  app_lvl_r, app_lvl_nxt;
  logic              op_r, op_nxt, ok_r, ok_nxt, done_r, done_nxt;
  logic [IDX_W-1:0]  res_r, res_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic              rebuild;
  logic [LINK_W-1:0] upv;

  assign rebuild = cfg_we;
  assign busy    = (state_r != ST_IDLE);
  assign done    = done_r;
  assign ok      = ok_r;
  assign res_idx = res_r;
  assign free_cnt = cnt_r;

  always_comb begin
    state_nxt = state_r;
    for (int i = 0; i < LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
    end
    total_nxt = total_r; eff_nxt = eff_r; top_nxt = top_r;
    lvl_nxt = lvl_r; cur_nxt = cur_r; cnt_nxt = cnt_r; ptr_nxt = ptr_r;
    node_nxt = node_r; prev_nxt = prev_r; tgt_nxt = tgt_r;
    app_nxt = app_r; app_lvl_nxt = app_lvl_r; op_nxt = op_r;
    ok_nxt = ok_r; res_nxt = res_r; done_nxt = 1'b0; steps_nxt = steps_r;
    link_req = '{we: 1'b0, addr: '0, wdata: NIL_LINK};
    upv = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt = cmd;
          lvl_nxt = ceil_log2(req);
          app_nxt = LINK_W'(idx);
          ok_nxt = 1'b0;
          res_nxt = '0;
          state_nxt = ST_DEC;
        end
      end
      ST_RB_CLR: begin
        link_req = '{we: 1'b1, addr: ptr_r[IDX_W-1:0], wdata: NIL_LINK};
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CNT_W'(MAX_BLOCKS - 1)) begin
          ptr_nxt = '0;
          state_nxt = (eff_r == '0) ? ST_IDLE : ST_RB_ADD;
        end
      end
      ST_RB_ADD: begin
        // free each index at level 0 in ascending order
        op_nxt = CMD_FREE;
        lvl_nxt = '0;
        app_nxt = LINK_W'(ptr_r);
        ptr_nxt = ptr_r + 1'b1;
        cur_nxt = '0;
        state_nxt = ST_F_LVL;
      end
      ST_DEC: begin
        if (op_r == CMD_ALLOC) begin
          if (lvl_r > top_r) state_nxt = ST_DONE;
          else begin
            cur_nxt = lvl_r;
            state_nxt = ST_A_SCAN;
          end
        end else begin
          if (lvl_r > top_r) state_nxt = ST_DONE;
          else begin
            ok_nxt = 1'b1;
            cnt_nxt = cnt_r + (CNT_W'(1) << lvl_r);
            cur_nxt = lvl_r;
            state_nxt = ST_F_LVL;
          end
        end
      end
      ST_A_SCAN: begin
        if (head_r[cur_r] < LINK_W'(MAX_BLOCKS)) begin
          node_nxt = head_r[cur_r];
          state_nxt = ST_A_RD;
        end else if (cur_r >= top_r) state_nxt = ST_DONE;
        else cur_nxt = cur_r + 1'b1;
      end
      ST_A_RD: begin
        link_req.addr = node_r[IDX_W-1:0];
        state_nxt = ST_A_HEAD;
      end
      ST_A_HEAD: begin
        head_nxt[cur_r] = link_rdata;
        if (link_rdata == NIL_LINK) tail_nxt[cur_r] = NIL_LINK;
        cnt_nxt = cnt_r - (CNT_W'(1) << lvl_r);
        ok_nxt = 1'b1;
        res_nxt = node_r[IDX_W-1:0];
        state_nxt = ST_A_SPL;
      end
      ST_A_SPL: begin
        if (cur_r > lvl_r) begin
          upv = node_r + (LINK_W'(1) << (cur_r - 1'b1));
          cur_nxt = cur_r - 1'b1;
          if (upv < LINK_W'(MAX_BLOCKS)) begin
            app_nxt = upv;
            app_lvl_nxt = cur_r - 1'b1;
            state_nxt = ST_APP;
          end
        end else state_nxt = ST_DONE;
      end
      ST_F_LVL: begin
        // try to unlink buddy at level cur_r
        if (cur_r < top_r) begin
          tgt_nxt = app_r ^ (LINK_W'(1) << cur_r);
          node_nxt = head_r[cur_r];
          prev_nxt = NIL_LINK;
          steps_nxt = '0;
          state_nxt = ST_F_RD;
        end else begin
          app_lvl_nxt = cur_r;
          state_nxt = ST_APP;
        end
      end
      ST_F_RD: begin
        if (node_r >= LINK_W'(MAX_BLOCKS) || steps_r == CNT_W'(MAX_BLOCKS)) begin
          app_lvl_nxt = cur_r;
          state_nxt = ST_APP;
        end else begin
          link_req.addr = node_r[IDX_W-1:0];
          state_nxt = ST_F_CMP;
        end
      end
      ST_F_CMP: begin
        if (node_r == tgt_r) begin
          if (prev_r == NIL_LINK) begin
            head_nxt[cur_r] = link_rdata;
            if (link_rdata == NIL_LINK) tail_nxt[cur_r] = NIL_LINK;
          end else begin
            link_req = '{we: 1'b1, addr: prev_r[IDX_W-1:0], wdata: link_rdata};
            if (node_r == tail_r[cur_r]) tail_nxt[cur_r] = prev_r;
          end
          if (tgt_r < app_r) app_nxt = tgt_r;
          cur_nxt = cur_r + 1'b1;
          state_nxt = ST_F_LVL;
        end else begin
          prev_nxt = node_r;
          node_nxt = link_rdata;
          steps_nxt = steps_r + 1'b1;
          state_nxt = ST_F_RD;
        end
      end
      ST_APP: begin
        link_req = '{we: 1'b1, addr: app_r[IDX_W-1:0], wdata: NIL_LINK};
        if (head_r[app_lvl_r] == NIL_LINK) begin
          head_nxt[app_lvl_r] = app_r;
          tail_nxt[app_lvl_r] = app_r;
          state_nxt = ST_APP2;
        end else begin
          tail_nxt[app_lvl_r] = app_r;
          prev_nxt = tail_r[app_lvl_r];
          state_nxt = ST_APP2;
        end
      end
      ST_APP2: begin
        if (prev_r < LINK_W'(MAX_BLOCKS)) begin
          link_req = '{we: 1'b1, addr: prev_r[IDX_W-1:0], wdata: app_r};
        end
        if (op_r == CMD_ALLOC) state_nxt = ST_A_SPL;
        else if (ok_r) state_nxt = ST_DONE;
        else if (ptr_r < eff_r) state_nxt = ST_RB_ADD;
        else state_nxt = ST_IDLE;
      end
      ST_DONE: begin
        done_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_APP && head_r[app_lvl_r] == NIL_LINK) prev_nxt = NIL_LINK;
    if (rebuild) begin
      total_nxt = cfg_wdata;
      eff_nxt = (cfg_wdata > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_wdata;
      top_nxt = floor_log2(eff_nxt);
      cnt_nxt = eff_nxt;
      for (int i = 0; i < LEVELS; i++) begin
        head_nxt[i] = NIL_LINK;
        tail_nxt[i] = NIL_LINK;
      end
      ptr_nxt = '0;
      ok_nxt = 1'b0;
      done_nxt = 1'b0;
      state_nxt = ST_RB_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RB_CLR;
      total_r <= CNT_W'(1024);
      eff_r   <= CNT_W'(MAX_BLOCKS);
      top_r   <= LVL_W'(IDX_W);
      cnt_r   <= CNT_W'(MAX_BLOCKS);
      ptr_r   <= '0;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= NIL_LINK;
        tail_r[i] <= NIL_LINK;
      end
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      eff_r   <= eff_nxt;
      top_r   <= top_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      done_r  <= done_nxt;
      ok_r    <= ok_nxt;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt; cur_r <= cur_nxt; node_r <= node_nxt;
    prev_r <= prev_nxt; tgt_r <= tgt_nxt; app_r <= app_nxt;
    app_lvl_r <= app_lvl_nxt; op_r <= op_nxt; res_r <= res_nxt;
    steps_r <= steps_nxt;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == ST_IDLE) else $error("done outside idle");
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= LVL_W'(IDX_W)) else $error("top level out of range");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !ok_r) |-> res_r == '0) else $error("failed result index");
  a_start_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> state_r == ST_DEC) else $error("start lost");
endmodule

// ===== rtl/core/buddy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over block indices with FIFO free lists per level.
// ----------------------------------------------------------------------------
// Hold start high until a cycle with busy low to issue a word: in_cmd selects
// allocate or free, in_request_blocks sets the level, in_block_index the
// region to free. The result word appears on out_ok, out_result_index and
// out_free_blocks for exactly one cycle, marked by out_valid; the receiver
// cannot stall it. busy falls in that same cycle, so the next word may be
// issued alongside it. Only one word is in flight at a time.
// Allocate scans upward one level at a time for a non-empty list and then
// splits halves back down; free tries each level in turn, walking that
// level's list node by node while looking for a buddy to merge with, and
// the list walk goes through the single-port link memory.
// After reset, and after a cfg_we write of total blocks, the block clears
// the link memory and then frees every index below the total (capped at
// MAX_BLOCKS) in ascending order with busy high.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [CNT_W-1:0]  in_request_blocks,
  input  logic [IDX_W-1:0]  in_block_index,
  output logic              out_valid,
  output logic              out_ok,
  output logic [IDX_W-1:0]  out_result_index,
  output logic [CNT_W-1:0]  out_free_blocks
);
  link_req_t         link_req;
  logic [LINK_W-1:0] link_rdata;

  bba_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_link (
    .clk(clk), .we(link_req.we), .addr(link_req.addr),
    .wdata(link_req.wdata), .rdata(link_rdata)
  );

  bba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .cmd(in_cmd), .req(in_request_blocks), .idx(in_block_index),
    .link_rdata(link_rdata), .link_req(link_req), .busy(busy),
    .done(out_valid), .ok(out_ok), .res_idx(out_result_index),
    .free_cnt(out_free_blocks)
  );
endmodule
